// ===== rtl/b64enc_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
`timescale 1ns / 1ps

package b64enc_pkg;

    localparam int Q_DEPTH = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Characters that one input byte produces, lowest slot first.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            last;
    } b64_entry_t;

    // Map a 6-bit index onto A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] v;
        v = {2'b00, idx};
        if (idx < 6'd26) begin
            return v + 8'h41;
        end else if (idx < 6'd52) begin
            return v + 8'h47;
        end else if (idx < 6'd62) begin
            return v + 8'hFC;
        end else if (idx == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

// ===== rtl/b64enc_front.sv =====
// Front end: accepts bytes, tracks group position and builds the characters per byte.
`timescale 1ns / 1ps

module b64enc_front
    import b64enc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       q_ready,
    output logic       q_push,
    output b64_entry_t q_entry
);

    typedef enum logic [2:0] {
        PH0 = 3'b001,
        PH1 = 3'b010,
        PH2 = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] left_reg, left_next;

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        q_entry    = '0;
        q_entry.last = s_tlast;
        unique case (phase_reg)
            PH1: begin
                q_entry.chars[0] = b64_char({left_reg[1:0], s_tdata[7:4]});
                if (s_tlast) begin
                    q_entry.chars[1] = b64_char({s_tdata[3:0], 2'b00});
                    q_entry.chars[2] = PAD_CHAR;
                    q_entry.last_idx = 2'd2;
                end else begin
                    phase_next = PH2;
                    left_next  = s_tdata[3:0];
                end
            end
            PH2: begin
                q_entry.chars[0] = b64_char({left_reg, s_tdata[7:6]});
                q_entry.chars[1] = b64_char(s_tdata[5:0]);
                q_entry.last_idx = 2'd1;
                phase_next = PH0;
                left_next  = '0;
            end
            default: begin
                q_entry.chars[0] = b64_char(s_tdata[7:2]);
                if (s_tlast) begin
                    q_entry.chars[1] = b64_char({s_tdata[1:0], 4'b0000});
                    q_entry.chars[2] = PAD_CHAR;
                    q_entry.chars[3] = PAD_CHAR;
                    q_entry.last_idx = 2'd3;
                end else begin
                    phase_next = PH1;
                    left_next  = {2'b00, s_tdata[1:0]};
                end
            end
        endcase
        // End of message restarts the group.
        if (s_tlast) begin
            phase_next = PH0;
            left_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH0;
            left_reg  <= '0;
        end else if (q_push) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ===== rtl/b64enc_queue.sv =====
// Small register queue between the front end and the character emitter.
`timescale 1ns / 1ps

module b64enc_queue
    import b64enc_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  b64_entry_t push_entry,
    output logic       q_ready,
    input  logic       pop,
    output logic       q_valid,
    output b64_entry_t q_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64_entry_t         mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_ready = (count_reg != CNT_W'(DEPTH));
    assign q_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/b64enc_back.sv =====
// Back end: pops byte records and emits their characters one beat per cycle while m_tready is high.
`timescale 1ns / 1ps

module b64enc_back
    import b64enc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  b64_entry_t q_entry,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    b64_entry_t cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;

    logic load_out;
    logic done;

    assign load_out = cur_valid_reg && (!m_tvalid_reg || m_tready);
    assign done     = load_out && (idx_reg == cur_reg.last_idx);
    assign pop      = q_valid && (!cur_valid_reg || done);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (done) begin
                cur_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end else if (load_out) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= q_entry;
        end
        if (load_out) begin
            m_tdata_reg <= cur_reg.chars[idx_reg];
            m_tlast_reg <= cur_reg.last && (idx_reg == cur_reg.last_idx);
        end
    end

`ifndef ASSERT_OFF
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (idx_reg <= cur_reg.last_idx))
        else $error("character index ran past the record");

    a_idx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !cur_valid_reg |-> (idx_reg == 2'd0))
        else $error("character index not cleared while idle");

    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid_reg && !cur_valid_reg) |=> !m_tvalid_reg)
        else $error("beat emitted without a record in hand");
`endif

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// A byte's record reaches its first beat via the queue, record register and output register.
// Throughput: one character beat per cycle while m_tready is high, set by the single output
// register of the character emitter; a byte yields 1 to 4 characters (4 chars per 3 bytes).
// The input stalls only when the record queue between front and back end is full.
// Reset: synchronous, active-low aresetn clears group position, queue and output valid.
`timescale 1ns / 1ps

module base64_stream_encoder
    import b64enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // last_char
);

    logic       q_push;
    logic       q_ready;
    logic       q_pop;
    logic       q_valid;
    b64_entry_t front_entry;
    b64_entry_t head_entry;

    b64enc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_entry  (front_entry)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (front_entry),
        .q_ready    (q_ready),
        .pop        (q_pop),
        .q_valid    (q_valid),
        .q_entry    (head_entry)
    );

    b64enc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (head_entry),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
